// ===== rtl/core/tior_pkg.sv =====
// Shared types and codes for the typed I/O register file.
package tior_pkg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_PAIR,
        S_OUT
    } t_state;

    localparam logic [1:0] FN_READ   = 2'd0;
    localparam logic [1:0] FN_WRITE  = 2'd1;
    localparam logic [1:0] FN_MASKED = 2'd2;
    localparam logic [1:0] FN_LOAD   = 2'd3;

    localparam logic [3:0] TY_RESERVED    = 4'd0;
    localparam logic [3:0] TY_PLAIN       = 4'd1;
    localparam logic [3:0] TY_CLEAR       = 4'd2;
    localparam logic [3:0] TY_TLOW_FIRST  = 4'd3;
    localparam logic [3:0] TY_THIGH_FIRST = 4'd9;
    localparam logic [3:0] TY_THIGH_LAST  = 4'd14;

    localparam logic [7:0] RESERVED_READ = 8'hFF;

    typedef struct packed {
        logic       reserved;
        logic       plain;
        logic       clr;
        logic       tlow;
        logic       thigh;
        logic [2:0] timer;
    } t_type_info;

endpackage

// ===== rtl/core/typed_io_register_file.sv =====
// Top level: typed 8-bit I/O register file with timer pair latching.
//
// Request channel (i_valid/o_ready) carries func, address, data, mask and
// type code; response channel (o_valid/i_ready) returns one read_data beat
// per request, zero for anything but a read.
// Bytes and type codes sit in two synchronous single-write-port memories;
// each request reads both, then modifies and writes back.
// Response: the request and both memory reads are registered at the accepting
// edge; the response register loads from S_LOOK, or from S_PAIR for a timer-low read
// or write (second byte-memory access for the partner high byte), or from
// S_OUT once free; o_ready is high only between requests, so requests never overlap.
// A waiting response does not stop the next request from being taken; a
// request that completes while the response register is still full parks in
// a holding register until i_ready frees it.
// Reset (synchronous, active low) starts a clearing pass that zeroes both
// memories, one entry per cycle, over min(NUM_REGS, 257) entries; o_ready stays
// low until it ends. Timer temporaries reset at once.
module typed_io_register_file #(
    parameter int NUM_REGS   = 256,
    parameter int NUM_TIMERS = 6
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_func,
    input  logic [7:0] i_address,
    input  logic [7:0] i_data,
    input  logic [7:0] i_mask,
    input  logic [3:0] i_type_code,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data
);
    import tior_pkg::*;

    localparam int DEPTH = (NUM_REGS < 257) ? NUM_REGS : 257;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam bit WRAPS = NUM_REGS <= 256;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [AW-1:0] WRAP_IDX = AW'(NUM_REGS - 1);

    logic [7:0] r_bytes_mem [DEPTH];
    logic [3:0] r_types_mem [DEPTH];

    t_state     r_state, n_state;
    logic [1:0] r_func;
    logic [7:0] r_addr;
    logic [7:0] r_data;
    logic [7:0] r_mask;
    logic [3:0] r_code;
    logic [7:0] r_byte;
    logic [3:0] r_ty;
    logic [7:0] r_res;
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic [AW-1:0] r_clr_idx;
    logic [7:0] r_temp [NUM_TIMERS];

    logic          accept;
    logic          free;
    logic [AW-1:0] aidx;
    logic [AW-1:0] pidx;
    logic          in_range;
    t_type_info    info;
    logic [TW-1:0] tsel;
    logic [7:0]    temp_val;
    logic [7:0]    src;
    logic          is_rd;
    logic          is_wr;
    logic          need_pair;
    logic [7:0]    look_res;
    logic [7:0]    res_now;

    logic          bwe;
    logic [AW-1:0] bwa;
    logic [7:0]    bwd;
    logic          bre;
    logic [AW-1:0] rda;
    logic          twe;
    logic [AW-1:0] twa;
    logic [3:0]    twd;
    logic          tmp_we;
    logic [7:0]    tmp_wd;
    logic          out_load;

    assign accept      = i_valid && o_ready;
    assign free        = !r_out_valid || i_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_read_data = r_out_data;

    assign aidx     = AW'(r_addr);
    assign pidx     = (WRAPS && (aidx == WRAP_IDX)) ? '0 : aidx + AW'(1);
    assign in_range = int'(r_addr) < NUM_REGS;

    tior_decode #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_decode (
        .i_type    (r_ty),
        .i_in_range(in_range),
        .o_info    (info)
    );

    assign tsel      = info.timer[TW-1:0];
    assign temp_val  = r_temp[tsel];
    assign is_rd     = (r_func == FN_READ);
    assign is_wr     = (r_func == FN_WRITE) || (r_func == FN_MASKED);
    assign need_pair = (is_rd || is_wr) && info.tlow;
    assign src       = (r_func == FN_MASKED) ? ((r_byte & ~r_mask) | (r_data & r_mask))
                                             : r_data;

    always_comb begin
        look_res = '0;
        if (is_rd) begin
            if (info.reserved) begin
                look_res = RESERVED_READ;
            end else if (info.thigh) begin
                look_res = temp_val;
            end else begin
                look_res = r_byte;
            end
        end
    end

    assign res_now = (r_state == S_LOOK) ? look_res : r_res;

    always_comb begin
        n_state  = r_state;
        bwe      = 1'b0;
        bwa      = aidx;
        bwd      = src;
        bre      = 1'b0;
        rda      = AW'(i_address);
        twe      = 1'b0;
        twa      = aidx;
        twd      = r_code;
        tmp_we   = 1'b0;
        tmp_wd   = src;
        out_load = 1'b0;
        case (r_state)
            S_CLEAR: begin
                bwe = 1'b1;
                bwa = r_clr_idx;
                bwd = '0;
                twe = 1'b1;
                twa = r_clr_idx;
                twd = TY_RESERVED;
                if (r_clr_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    bre     = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (is_wr) begin
                    bwe    = info.plain || info.clr || info.tlow;
                    bwd    = info.clr ? (r_byte & ~src) : src;
                    tmp_we = info.thigh;
                end
                if ((r_func == FN_LOAD) && in_range) begin
                    twe = 1'b1;
                end
                if (need_pair) begin
                    bre     = is_rd;
                    rda     = pidx;
                    n_state = S_PAIR;
                end else if (free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_PAIR: begin
                if (is_rd) begin
                    tmp_we = 1'b1;
                    tmp_wd = r_byte;
                end else begin
                    bwe = 1'b1;
                    bwa = pidx;
                    bwd = temp_val;
                end
                if (free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_idx <= r_clr_idx + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_temp[i] <= '0;
            end
        end else if (tmp_we) begin
            r_temp[tsel] <= tmp_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_func;
            r_addr <= i_address;
            r_data <= i_data;
            r_mask <= i_mask;
            r_code <= i_type_code;
        end
        if (r_state == S_LOOK) begin
            r_res <= look_res;
        end
        if (out_load) begin
            r_out_data <= res_now;
        end
    end

    // byte store: one write, one read per cycle
    always_ff @(posedge i_clk) begin
        if (bwe) begin
            r_bytes_mem[bwa] <= bwd;
        end
        if (bre) begin
            r_byte <= r_bytes_mem[rda];
        end
    end

    // type store
    always_ff @(posedge i_clk) begin
        if (twe) begin
            r_types_mem[twa] <= twd;
        end
        if (accept) begin
            r_ty <= r_types_mem[AW'(i_address)];
        end
    end

endmodule

// ===== rtl/core/tior_decode.sv =====
// Effective type decode: folds invalid addresses, codes and timers to reserved.
module tior_decode #(
    parameter int NUM_TIMERS = 6
) (
    input  logic [3:0]           i_type,
    input  logic                 i_in_range,
    output tior_pkg::t_type_info o_info
);
    import tior_pkg::*;

    logic       is_low;
    logic       is_high;
    logic [3:0] tn;
    logic       timer_ok;

    always_comb begin
        is_low   = i_type inside {[TY_TLOW_FIRST : TY_THIGH_FIRST - 4'd1]};
        is_high  = i_type inside {[TY_THIGH_FIRST : TY_THIGH_LAST]};
        tn       = is_high ? (i_type - TY_THIGH_FIRST) : (i_type - TY_TLOW_FIRST);
        timer_ok = int'(tn) < NUM_TIMERS;

        o_info.plain    = i_in_range && (i_type == TY_PLAIN);
        o_info.clr      = i_in_range && (i_type == TY_CLEAR);
        o_info.tlow     = i_in_range && is_low && timer_ok;
        o_info.thigh    = i_in_range && is_high && timer_ok;
        o_info.reserved = !(o_info.plain || o_info.clr || o_info.tlow || o_info.thigh);
        o_info.timer    = tn[2:0];
    end

endmodule

// ===== rtl/core/tior_chk.sv =====
// Port-level checks for the typed I/O register file, bound to the top level.
module tior_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_read_data
);

    a_no_resp_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response beat valid right after reset");

    a_clear_blocks_req: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_ready)
        else $error("request taken during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request taken while previous still in flight");

    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_read_data)))
        else $error("stalled response beat changed");

endmodule

bind typed_io_register_file tior_chk u_tior_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_read_data(o_read_data)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the typed I/O register file: scripted and random accesses.
module testbench;
    import tior_pkg::*;

    localparam int         NUM_TIMERS   = 6;
    localparam logic [3:0] TY_UNDEFINED = 4'd15;
    localparam int         RANDOM_BEATS = 700;
    localparam int         SCRIPT_LEN   = 25;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] addr;
        logic [7:0] data;
        logic [7:0] mask;
        logic [3:0] code;
        logic       fixed;
        logic [7:0] read_val;
    } t_script_row;

    // fixed = 1: read_val is the expected byte; otherwise the mirror decides
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{FN_READ,   8'h00, 8'h00, 8'h00, TY_RESERVED,          1'b1, RESERVED_READ},
        '{FN_WRITE,  8'h00, 8'hA5, 8'h00, TY_RESERVED,          1'b1, 8'h00},
        '{FN_READ,   8'h00, 8'h00, 8'h00, TY_RESERVED,          1'b1, RESERVED_READ},
        '{FN_LOAD,   8'h10, 8'h00, 8'h00, TY_PLAIN,             1'b1, 8'h00},
        '{FN_WRITE,  8'h10, 8'hFF, 8'h00, TY_RESERVED,          1'b1, 8'h00},
        '{FN_READ,   8'h10, 8'h00, 8'h00, TY_RESERVED,          1'b1, 8'hFF},
        '{FN_MASKED, 8'h10, 8'h00, 8'h0F, TY_RESERVED,          1'b1, 8'h00},
        '{FN_READ,   8'h10, 8'h00, 8'hFF, TY_RESERVED,          1'b0, 8'h00},
        '{FN_LOAD,   8'h20, 8'h00, 8'h00, TY_PLAIN,             1'b0, 8'h00},
        '{FN_WRITE,  8'h20, 8'hFF, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_LOAD,   8'h20, 8'h00, 8'h00, TY_CLEAR,             1'b0, 8'h00},
        '{FN_WRITE,  8'h20, 8'h0F, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_READ,   8'h20, 8'h00, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_MASKED, 8'h20, 8'hFF, 8'h30, TY_RESERVED,          1'b0, 8'h00},
        '{FN_LOAD,   8'hFF, 8'h00, 8'h00, TY_TLOW_FIRST + 4'd5, 1'b0, 8'h00},
        '{FN_LOAD,   8'h00, 8'h00, 8'h00, TY_THIGH_LAST,        1'b0, 8'h00},
        '{FN_WRITE,  8'h00, 8'h12, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_WRITE,  8'hFF, 8'h34, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_READ,   8'hFF, 8'h00, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_READ,   8'h00, 8'h00, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_MASKED, 8'h00, 8'hFF, 8'hF0, TY_RESERVED,          1'b0, 8'h00},
        '{FN_WRITE,  8'hFF, 8'h00, 8'h00, TY_RESERVED,          1'b0, 8'h00},
        '{FN_LOAD,   8'h30, 8'h00, 8'h00, TY_UNDEFINED,         1'b1, 8'h00},
        '{FN_READ,   8'h30, 8'h00, 8'h00, TY_RESERVED,          1'b1, RESERVED_READ},
        '{FN_MASKED, 8'h30, 8'h55, 8'hAA, TY_RESERVED,          1'b1, 8'h00}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [1:0] i_func;
    logic [7:0] i_address;
    logic [7:0] i_data;
    logic [7:0] i_mask;
    logic [3:0] i_type_code;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_read_data;

    logic [7:0] mirror_byte [256];
    logic [3:0] mirror_type [256];
    logic [7:0] mirror_temp [NUM_TIMERS];

    logic [7:0] expected_read_q [$];
    logic [7:0] want_read;
    int         mismatches   = 0;
    int         beats_issued = 0;
    int         src_idle_pct = 0;
    int         sink_stall_pct = 0;
    int         src_idle_pcts  [3] = '{24, 49, 0};
    int         sink_stall_pcts[3] = '{49, 24, 0};

    typed_io_register_file dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_func      (i_func),
        .i_address   (i_address),
        .i_data      (i_data),
        .i_mask      (i_mask),
        .i_type_code (i_type_code),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_read_data (o_read_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(2_000_000);
        $display("FAILURE");
        $finish;
    end

    // invalid codes and out-of-range timers fold to reserved
    function automatic logic [3:0] live_type(input logic [7:0] a);
        logic [3:0] t;
        int         tn;
        t = mirror_type[a];
        if (t > TY_THIGH_LAST) return TY_RESERVED;
        if (t >= TY_TLOW_FIRST) begin
            tn = (t >= TY_THIGH_FIRST) ? int'(t - TY_THIGH_FIRST) : int'(t - TY_TLOW_FIRST);
            if (tn >= NUM_TIMERS) return TY_RESERVED;
        end
        return t;
    endfunction

    function automatic logic [7:0] byte_read(input logic [7:0] a);
        logic [3:0] t;
        t = live_type(a);
        if (t == TY_RESERVED) return RESERVED_READ;
        if (t == TY_PLAIN || t == TY_CLEAR) return mirror_byte[a];
        if (t < TY_THIGH_FIRST) begin
            mirror_temp[t - TY_TLOW_FIRST] = mirror_byte[a + 8'd1];
            return mirror_byte[a];
        end
        return mirror_temp[t - TY_THIGH_FIRST];
    endfunction

    function automatic void byte_write(input logic [7:0] a, input logic [7:0] v);
        logic [3:0] t;
        t = live_type(a);
        if (t == TY_PLAIN) begin
            mirror_byte[a] = v;
        end else if (t == TY_CLEAR) begin
            mirror_byte[a] = mirror_byte[a] & ~v;
        end else if (t != TY_RESERVED && t < TY_THIGH_FIRST) begin
            mirror_byte[a + 8'd1] = mirror_temp[t - TY_TLOW_FIRST];
            mirror_byte[a] = v;
        end else if (t != TY_RESERVED) begin
            mirror_temp[t - TY_THIGH_FIRST] = v;
        end
    endfunction

    function automatic logic [7:0] predict_access(input logic [1:0] f, input logic [7:0] a,
                                                  input logic [7:0] d, input logic [7:0] m,
                                                  input logic [3:0] c);
        logic [7:0] rd;
        rd = 8'h00;
        case (f)
            FN_READ:   rd = byte_read(a);
            FN_WRITE:  byte_write(a, d);
            FN_MASKED: byte_write(a, (mirror_byte[a] & ~m) | (d & m));
            default:   mirror_type[a] = c;
        endcase
        return rd;
    endfunction

    // mostly a small window so typed registers get hit again, plus the wrap pair
    function automatic logic [7:0] pick_address();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 8'h40 + 8'($urandom_range(7));
        if (r < 72) return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic issue(input logic [1:0] f, input logic [7:0] a, input logic [7:0] d,
                         input logic [7:0] m, input logic [3:0] c,
                         input logic fixed, input logic [7:0] fixed_val);
        logic [7:0] predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_func      <= f;
        i_address   <= a;
        i_data      <= d;
        i_mask      <= m;
        i_type_code <= c;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_access(f, a, d, m, c);
        expected_read_q.push_back(fixed ? fixed_val : predicted);
        beats_issued++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_read_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_single();
        logic [1:0] f;
        int         r;
        r = $urandom_range(99);
        if (r < 15)      f = FN_LOAD;
        else if (r < 50) f = FN_READ;
        else if (r < 75) f = FN_WRITE;
        else             f = FN_MASKED;
        issue(f, pick_address(), 8'($urandom), 8'($urandom), 4'($urandom_range(15)), 1'b0, 8'h00);
    endtask

    // timer pair set up, then random 16-bit style traffic on it
    task automatic timer_burst();
        logic [7:0] low_addr;
        logic [7:0] a;
        logic [3:0] n;
        logic [1:0] data_funcs [3];
        data_funcs = '{FN_READ, FN_WRITE, FN_MASKED};
        n = 4'($urandom_range(NUM_TIMERS - 1));
        low_addr = pick_address();
        issue(FN_LOAD, low_addr, 8'($urandom), 8'($urandom), TY_TLOW_FIRST + n, 1'b0, 8'h00);
        issue(FN_LOAD, low_addr + 8'd1, 8'($urandom), 8'($urandom), TY_THIGH_FIRST + n,
              1'b0, 8'h00);
        repeat ($urandom_range(6, 3)) begin
            a = $urandom_range(1) ? low_addr : low_addr + 8'd1;
            issue(data_funcs[$urandom_range(2)], a, 8'($urandom), 8'($urandom),
                  4'($urandom_range(15)), 1'b0, 8'h00);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_read_q.size() == 0) begin
                mismatches++;
                $display("%0t: read_data beat %02h with none expected", $time, o_read_data);
            end else begin
                want_read = expected_read_q.pop_front();
                if (o_read_data !== want_read) begin
                    mismatches++;
                    $display("%0t: read_data expected %02h, got %02h",
                             $time, want_read, o_read_data);
                end
            end
        end
        i_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    initial begin
        int random_start;
        foreach (mirror_byte[k]) begin
            mirror_byte[k] = 8'h00;
            mirror_type[k] = TY_RESERVED;
        end
        foreach (mirror_temp[k]) mirror_temp[k] = 8'h00;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_func      <= FN_READ;
        i_address   <= 8'h00;
        i_data      <= 8'h00;
        i_mask      <= 8'h00;
        i_type_code <= TY_RESERVED;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct   = src_idle_pcts[0];
        sink_stall_pct = sink_stall_pcts[0];
        foreach (SCRIPT[k])
            issue(SCRIPT[k].func, SCRIPT[k].addr, SCRIPT[k].data, SCRIPT[k].mask,
                  SCRIPT[k].code, SCRIPT[k].fixed, SCRIPT[k].read_val);

        random_start = beats_issued;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct   = src_idle_pcts[phase];
            sink_stall_pct = sink_stall_pcts[phase];
            while (beats_issued - random_start < (phase + 1) * RANDOM_BEATS / 3) begin
                if ($urandom_range(99) < 20) timer_burst();
                else                         random_single();
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_read_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== typed_io_register_file.f =====
rtl/core/tior_pkg.sv
rtl/core/tior_decode.sv
rtl/core/typed_io_register_file.sv
rtl/core/tior_chk.sv
tb/testbench.sv
